// ----- rtl/audio_block_rms_peak_meter_defines.svh -----
// Assertion macros for the meter's RTL; ablm_ctrl.sv includes them.
// Define NO_ASSERTIONS to build without them.
`ifndef AUDIO_BLOCK_RMS_PEAK_METER_DEFINES_SVH
`define AUDIO_BLOCK_RMS_PEAK_METER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define ABLM_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle implication check failed.");

`define ABLM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle implication check failed.");

`define ABLM_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("Forbidden condition seen.");

`else

`define ABLM_ASSERT_IMPLIES(label, ante, cons)
`define ABLM_ASSERT_NEXT(label, ante, cons)
`define ABLM_ASSERT_NEVER(label, cond)

`endif

`endif

// ----- rtl/ablm_pkg.sv -----
package ablm_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int LEVEL_BITS     = SAMPLE_BITS - 1;
    localparam int BAR_BITS       = 11;
    localparam int SPB_BITS       = 16;
    localparam int HH_BITS        = 11;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [SPB_BITS-1:0] SPB_RESET = SPB_BITS'(256);
    localparam logic [HH_BITS-1:0]  HH_RESET  = HH_BITS'(128);

    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};

    // Bar scaling: 0.8 = 4 / 5 and 0.9 = 9 / 10.
    localparam int BAR_RMS_MUL  = 4;
    localparam int BAR_RMS_DIV  = 5;
    localparam int BAR_PEAK_MUL = 9;
    localparam int BAR_PEAK_DIV = 10;

    // The divisions by 5 and 10 are a multiply by the rounded-up reciprocal and a
    // shift; both are exact for every 15-bit dividend.
    localparam int BAR_RECIP_SHIFT = 18;
    localparam int BAR_RMS_RECIP   = ((1 << BAR_RECIP_SHIFT) + BAR_RMS_DIV - 1) / BAR_RMS_DIV;
    localparam int BAR_PEAK_RECIP  = ((1 << BAR_RECIP_SHIFT) + BAR_PEAK_DIV - 1) / BAR_PEAK_DIV;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLES_PER_BLOCK = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HALF_HEIGHT       = CFG_INDEX_BITS'(1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          end_of_data;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] rms_level;
        logic [LEVEL_BITS-1:0] peak_level;
        logic [BAR_BITS-1:0]   rms_bar;
        logic [BAR_BITS-1:0]   peak_bar;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_ROOT_WAIT,
        ST_BAR_MUL,
        ST_BAR_LOAD,
        ST_PUBLISH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic square;
        logic accum;
        logic div_start;
        logic sqrt_start;
        logic root_load;
        logic bar_mul;
        logic bar_load;
        logic publish;
    } dp_cmd_t;

    typedef struct packed {
        logic close;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/audio_block_rms_peak_meter.sv -----
// Block RMS and peak level meter.
// Input channel (in_valid / in_stall / in_data): one signed sample and an
// end-of-data flag per transfer. Output channel (out_valid / out_stall /
// out_data): one result per closed block with RMS, peak and both bar heights.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
// index 0 sets samples per block, index 1 sets the half height; cfg_ready is
// always high and writes belong in idle periods.
// A sample that does not close a block is captured, squared and added.
// A closing sample then runs the bit-serial divider once for the mean square
// and the square root once, and forms both bar heights by reciprocal
// multiplication, a multiply step and a reciprocal step. Its result then goes
// into the output register, and the block returns to idle for the next sample.
// The output register holds one result; while it waits the next block's
// samples are still taken. If a new result is ready while the receiver
// stalls, the block waits with in_stall high until that transfer completes.
// Reset clears the accumulators, empties the output register and restores
// 256 samples per block and a half height of 128.
module audio_block_rms_peak_meter #(
    parameter int COUNT_BITS = ablm_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  ablm_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output ablm_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ablm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ablm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import ablm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    ablm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ablm_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ----- rtl/ablm_div.sv -----
module ablm_div #(
    parameter int DW = 47,
    parameter int VW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DW - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    quo_reg;
    logic [VW-1:0]    rem_reg;
    logic [VW-1:0]    den_reg;

    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          ge;
    logic [VW-1:0] rem_next;
    logic [DW-1:0] quo_next;

    // Restoring division, one quotient bit per cycle, MSB first.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DW-1]};
        ge       = (shifted >= {1'b0, den_reg});
        diff     = shifted - {1'b0, den_reg};
        rem_next = ge ? diff[VW-1:0] : shifted[VW-1:0];
        quo_next = {quo_reg[DW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/ablm_sqrt.sv -----
module ablm_sqrt #(
    parameter int QW = 31
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [QW-1:0]             radicand,
    output logic                      done,
    output logic [(QW + QW % 2)/2-1:0] root
);
    localparam int EW    = QW + QW % 2;
    localparam int RW    = EW / 2;
    localparam int CNT_W = (RW > 1) ? $clog2(RW) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(RW - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [EW-1:0]    rad_reg;
    logic [RW+1:0]    rem_reg;
    logic [RW-1:0]    root_reg;

    logic [RW+3:0] rem_sh;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          ge;

    // Digit-by-digit square root, two radicand bits and one root bit per cycle.
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[EW-1:EW-2]};
        trial  = (RW+4)'({root_reg, 2'b01});
        ge     = (rem_sh >= trial);
        diff   = rem_sh - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= EW'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[EW-3:0], 2'b00};
            rem_reg  <= ge ? diff[RW+1:0] : rem_sh[RW+1:0];
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/ablm_datapath.sv -----
module ablm_datapath #(
    parameter int COUNT_BITS = ablm_pkg::COUNT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ablm_pkg::in_item_t                   in_data,
    input  ablm_pkg::dp_cmd_t                    cmd,
    output ablm_pkg::dp_status_t                 status,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ablm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ablm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output ablm_pkg::out_item_t                  out_data
);
    import ablm_pkg::*;

    localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W  = SQ_W + COUNT_BITS;
    localparam int LIM_W  = (COUNT_BITS > SPB_BITS) ? COUNT_BITS : SPB_BITS;
    localparam int PROD_W = LEVEL_BITS + HH_BITS;
    localparam int SCL_W  = PROD_W + 4;
    localparam int BQ_W   = SCL_W - LEVEL_BITS;
    localparam int RCP_W  = BQ_W + BAR_RECIP_SHIFT;
    localparam int ROOT_W = (SQ_W + SQ_W % 2) / 2;
    localparam logic [LIM_W-1:0] COUNT_MAX = LIM_W'({COUNT_BITS{1'b1}});

    logic [SPB_BITS-1:0]    spb_reg;
    logic [HH_BITS-1:0]     hh_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic                   last_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SAMPLE_BITS-1:0] peak_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [LEVEL_BITS-1:0]  rms_lvl_reg;
    logic [LEVEL_BITS-1:0]  peak_lvl_reg;
    logic [PROD_W-1:0]      rms_prod_reg;
    logic [PROD_W-1:0]      peak_prod_reg;
    logic [BAR_BITS-1:0]    rms_bar_reg;
    logic [BAR_BITS-1:0]    peak_bar_reg;
    logic                   out_valid_reg;
    out_item_t              out_reg;

    logic [SAMPLE_BITS-1:0]   raw_u;
    logic [SAMPLE_BITS-1:0]   mag_c;
    logic [2*SAMPLE_BITS-1:0] sq_full;
    logic [LIM_W-1:0]         spb_ext;
    logic [LIM_W-1:0]         limit_c;
    logic [SCL_W-1:0]         rms_scaled;
    logic [SCL_W-1:0]         peak_scaled;
    logic [RCP_W-1:0]         rms_rcp;
    logic [RCP_W-1:0]         peak_rcp;
    logic                     div_done;
    logic [SUM_W-1:0]         div_quotient;
    logic                     sqrt_done;
    logic [ROOT_W-1:0]        sqrt_root;

    // Magnitude of the sample; the most negative code gives full scale.
    always_comb
    begin
        raw_u = in_data.sample;
        mag_c = raw_u[SAMPLE_BITS-1] ? (~raw_u + SAMPLE_BITS'(1)) : raw_u;
        sq_full = (2*SAMPLE_BITS)'(mag_reg) * (2*SAMPLE_BITS)'(mag_reg);
    end

    // A block length of zero acts as one, and the length is capped by the counter.
    always_comb
    begin
        spb_ext = LIM_W'(spb_reg);
        if (spb_reg == '0)
            limit_c = LIM_W'(1);
        else if (spb_ext > COUNT_MAX)
            limit_c = COUNT_MAX;
        else
            limit_c = spb_ext;
    end

    // Bar heights: scale, drop the level fraction, then divide by 5 or 10.
    always_comb
    begin
        rms_scaled  = SCL_W'(rms_prod_reg) * SCL_W'(BAR_RMS_MUL);
        peak_scaled = SCL_W'(peak_prod_reg) * SCL_W'(BAR_PEAK_MUL);
        rms_rcp     = RCP_W'(rms_scaled[SCL_W-1:LEVEL_BITS]) * RCP_W'(BAR_RMS_RECIP);
        peak_rcp    = RCP_W'(peak_scaled[SCL_W-1:LEVEL_BITS]) * RCP_W'(BAR_PEAK_RECIP);
    end

    ablm_div #(
        .DW (SUM_W),
        .VW (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // The mean square never exceeds the largest square, so its low bits suffice.
    ablm_sqrt #(
        .QW (SQ_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (div_quotient[SQ_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg <= SPB_RESET;
            hh_reg  <= HH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SAMPLES_PER_BLOCK: spb_reg <= cfg_data[SPB_BITS-1:0];
                CFG_HALF_HEIGHT:       hh_reg  <= cfg_data[HH_BITS-1:0];
                default:               ;
            endcase
        end
    end

    // Block accumulators; cleared when the block's mean division starts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            peak_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            sum_reg   <= '0;
            peak_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.square)
            begin
                count_reg <= count_reg + COUNT_BITS'(1);
                if (mag_reg > peak_reg)
                    peak_reg <= mag_reg;
            end
            if (cmd.accum)
                sum_reg <= sum_reg + SUM_W'(sq_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mag_reg  <= mag_c;
            last_reg <= in_data.end_of_data;
        end
        if (cmd.square)
            sq_reg <= sq_full[SQ_W-1:0];
        if (cmd.div_start)
            peak_lvl_reg <= peak_reg[SAMPLE_BITS-1] ? LEVEL_MAX : peak_reg[LEVEL_BITS-1:0];
        if (cmd.root_load)
            rms_lvl_reg <= (ROOT_W'(sqrt_root) > ROOT_W'(LEVEL_MAX)) ?
                           LEVEL_MAX : sqrt_root[LEVEL_BITS-1:0];
        if (cmd.bar_mul)
        begin
            rms_prod_reg  <= PROD_W'(rms_lvl_reg) * PROD_W'(hh_reg);
            peak_prod_reg <= PROD_W'(peak_lvl_reg) * PROD_W'(hh_reg);
        end
        if (cmd.bar_load)
        begin
            rms_bar_reg  <= rms_rcp[BAR_RECIP_SHIFT +: BAR_BITS];
            peak_bar_reg <= peak_rcp[BAR_RECIP_SHIFT +: BAR_BITS];
        end
        if (cmd.publish)
        begin
            out_reg.rms_level  <= rms_lvl_reg;
            out_reg.peak_level <= peak_lvl_reg;
            out_reg.rms_bar    <= rms_bar_reg;
            out_reg.peak_bar   <= peak_bar_reg;
        end
    end

    // Output register: loaded only when empty or when its result transfers this cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.publish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_comb
    begin
        status.close     = last_reg || (LIM_W'(count_reg) >= limit_c);
        status.div_done  = div_done;
        status.sqrt_done = sqrt_done;
        status.out_free  = !out_valid_reg || !out_stall;
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- rtl/ablm_ctrl.sv -----
`include "audio_block_rms_peak_meter_defines.svh"

module ablm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ablm_pkg::dp_status_t status,
    output ablm_pkg::dp_cmd_t    cmd
);
    import ablm_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = status.close ? ST_MEAN_GO : ST_IDLE;
            end
            ST_MEAN_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_ROOT_WAIT;
                end
            end
            ST_ROOT_WAIT:
            begin
                if (status.sqrt_done)
                begin
                    cmd.root_load = 1'b1;
                    state_next    = ST_BAR_MUL;
                end
            end
            ST_BAR_MUL:
            begin
                cmd.bar_mul = 1'b1;
                state_next  = ST_BAR_LOAD;
            end
            ST_BAR_LOAD:
            begin
                cmd.bar_load = 1'b1;
                state_next   = ST_PUBLISH;
            end
            ST_PUBLISH:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ABLM_ASSERT_NEXT(a_accept_starts_square, in_valid && !in_stall, state_reg == ST_SQUARE)
    `ABLM_ASSERT_NEVER(a_div_done_stray, status.div_done && (state_reg != ST_MEAN_WAIT))
    `ABLM_ASSERT_IMPLIES(a_sqrt_done_in_root, status.sqrt_done, state_reg == ST_ROOT_WAIT)

endmodule

// ----- tb/ablm_checker.sv -----
`timescale 1ns / 100ps

module ablm_checker
    import ablm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  in_item_t                  in_data,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  out_item_t                 out_data,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        mismatches,
    output int                        blocks_waiting,
    output int                        blocks_checked
);

    localparam logic [63:0] FULL_SCALE = 64'd1 << (SAMPLE_BITS - 1);

    logic [SPB_BITS-1:0] block_len;
    logic [HH_BITS-1:0]  bar_ref;
    logic [63:0]         energy;
    logic [16:0]         peak_mag;
    logic [15:0]         sample_count;
    out_item_t           pending_levels[$];

    function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= v)
                root = trial;
        end
        return root;
    endfunction

    // Levels and bars of the block accumulated so far.
    function automatic out_item_t block_levels();
        out_item_t   lv;
        logic [63:0] rms;
        logic [63:0] peak;
        rms  = 64'(floor_sqrt(energy / 64'(sample_count)));
        peak = 64'(peak_mag);
        if (rms > 64'(LEVEL_MAX))
            rms = 64'(LEVEL_MAX);
        if (peak > 64'(LEVEL_MAX))
            peak = 64'(LEVEL_MAX);
        lv.rms_level  = rms[LEVEL_BITS-1:0];
        lv.peak_level = peak[LEVEL_BITS-1:0];
        lv.rms_bar    = BAR_BITS'((rms * 64'(bar_ref) * BAR_RMS_MUL)
                                  / (BAR_RMS_DIV * FULL_SCALE));
        lv.peak_bar   = BAR_BITS'((peak * 64'(bar_ref) * BAR_PEAK_MUL)
                                  / (BAR_PEAK_DIV * FULL_SCALE));
        return lv;
    endfunction

    task automatic check_field(input string field, input logic [15:0] expected,
                               input logic [15:0] actual);
        if (expected !== actual)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, expected, actual);
        end
    endtask

    task automatic accumulate_sample(input in_item_t item);
        logic [16:0] mag;
        logic [16:0] limit;
        mag = (item.sample < 0) ? 17'(-int'(item.sample)) : 17'(item.sample);
        energy = energy + 64'(mag) * 64'(mag);
        if (mag > peak_mag)
            peak_mag = mag;
        if (sample_count != 16'hFFFF)
            sample_count++;
        // A zero length behaves as one; the 16-bit register never exceeds the counter.
        limit = (block_len == '0) ? 17'd1 : 17'(block_len);
        if (17'(sample_count) >= limit || item.end_of_data)
        begin
            pending_levels.push_back(block_levels());
            energy       = '0;
            peak_mag     = '0;
            sample_count = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_len      = SPB_RESET;
            bar_ref        = HH_RESET;
            energy         = '0;
            peak_mag       = '0;
            sample_count   = '0;
            mismatches     = 0;
            blocks_waiting = 0;
            blocks_checked = 0;
            pending_levels.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SAMPLES_PER_BLOCK)
                    block_len = cfg_data[SPB_BITS-1:0];
                else if (cfg_index == CFG_HALF_HEIGHT)
                    bar_ref = cfg_data[HH_BITS-1:0];
            end
            if (out_valid && !out_stall)
            begin
                blocks_checked++;
                if (pending_levels.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with no block pending, actual rms %0d peak %0d",
                             $time, out_data.rms_level, out_data.peak_level);
                end
                else
                begin
                    out_item_t want;
                    want = pending_levels.pop_front();
                    check_field("rms_level", 16'(want.rms_level), 16'(out_data.rms_level));
                    check_field("peak_level", 16'(want.peak_level),
                                16'(out_data.peak_level));
                    check_field("rms_bar", 16'(want.rms_bar), 16'(out_data.rms_bar));
                    check_field("peak_bar", 16'(want.peak_bar), 16'(out_data.peak_bar));
                end
            end
            if (in_valid && !in_stall)
                accumulate_sample(in_data);
            blocks_waiting = pending_levels.size();
        end
    end

endmodule

// ----- tb/tb_audio_block_rms_peak_meter.sv -----
`timescale 1ns / 100ps

module tb_audio_block_rms_peak_meter;
    import ablm_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_2 = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_3 = CFG_INDEX_BITS'(3);
    // A closing sample keeps the block busy through the divide and root; leave some margin.
    localparam int SETTLE_CYCLES = 250;
    localparam int PHASES        = 13;
    localparam int PHASE_SAMPLES = 150;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    in_item_t                  in_data;
    logic                      out_valid;
    logic                      out_stall;
    out_item_t                 out_data;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int   mismatches;
    int   blocks_waiting;
    int   blocks_checked;
    int   samples_sent;
    int   stall_len;
    logic calm;
    logic [SPB_BITS-1:0] spb_pick;
    logic [HH_BITS-1:0]  hh_pick;

    audio_block_rms_peak_meter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ablm_checker level_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .blocks_waiting (blocks_waiting),
        .blocks_checked (blocks_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("audio_block_rms_peak_meter test failed");
        $finish;
    end

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return SAMPLE_BITS'($urandom);
        else if (r < 70)
            return SAMPLE_BITS'($urandom_range(0, 511) - 256);
        else if (r < 80)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        return SAMPLE_BITS'($urandom_range(0, 8191) - 4096);
    endfunction

    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
        int gap;
        gap = calm ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid            <= 1'b1;
        in_data.sample      <= s;
        in_data.end_of_data <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        samples_sent++;
    endtask

    // Stop sending and wait for every outstanding block result.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (blocks_waiting != 0)
            @(negedge clk);
    endtask

    // The block must be fully idle before a register write.
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver side: random stall bursts between stall-free runs.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall_len = calm ? 0 : pick_gap();
            if (stall_len > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (stall_len - 1) @(negedge clk);
                @(negedge clk);
                out_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        calm         = 1'b0;
        samples_sent = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(negedge clk);

        // Reset settings: full-scale extremes closed early by end of data.
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh0000, 1'b0);
        push_sample(16'shFFFF, 1'b1);
        settle();

        // One-sample blocks; the most negative sample alone clamps both levels.
        write_reg(CFG_SAMPLES_PER_BLOCK, 16'd1);
        write_reg(CFG_HALF_HEIGHT, 16'hFFFF);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh0000, 1'b0);
        settle();

        // A block length of zero behaves as one.
        write_reg(CFG_SAMPLES_PER_BLOCK, 16'd0);
        write_reg(CFG_HALF_HEIGHT, 16'd0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh0001, 1'b0);
        settle();

        // Length lowered below the count part-way through a block.
        write_reg(CFG_SAMPLES_PER_BLOCK, 16'd10);
        write_reg(CFG_HALF_HEIGHT, 16'd1000);
        push_sample(16'sd100, 1'b0);
        push_sample(-16'sd200, 1'b0);
        push_sample(16'sd300, 1'b0);
        push_sample(-16'sd400, 1'b0);
        push_sample(16'sd500, 1'b0);
        push_sample(-16'sd600, 1'b0);
        settle();
        write_reg(CFG_SAMPLES_PER_BLOCK, 16'd4);
        push_sample(16'sd700, 1'b0);
        push_sample(-16'sd800, 1'b1);
        settle();

        // Longest block length, spare indexes that must be ignored.
        write_reg(CFG_SAMPLES_PER_BLOCK, 16'hFFFF);
        write_reg(CFG_HALF_HEIGHT, 16'h07FF);
        write_reg(CFG_SPARE_2, 16'hABCD);
        write_reg(CFG_SPARE_3, 16'h5432);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sd12345, 1'b1);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case ($urandom_range(0, 9))
                0:       spb_pick = 16'd0;
                1:       spb_pick = SPB_BITS'($urandom_range(1, 3));
                7:       spb_pick = SPB_BITS'($urandom_range(41, 300));
                8:       spb_pick = SPB_RESET;
                9:       spb_pick = SPB_BITS'($urandom_range(301, 5000));
                default: spb_pick = SPB_BITS'($urandom_range(4, 40));
            endcase
            case ($urandom_range(0, 4))
                0:       hh_pick = '0;
                1:       hh_pick = 11'h7FF;
                default: hh_pick = HH_BITS'($urandom_range(0, 2047));
            endcase
            write_reg(CFG_SAMPLES_PER_BLOCK, spb_pick);
            write_reg(CFG_HALF_HEIGHT, {5'($urandom), hh_pick});
            if ($urandom_range(0, 3) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_2 : CFG_SPARE_3,
                          CFG_DATA_BITS'($urandom));
            calm = (phase % 4 == 3);
            for (int i = 0; i < PHASE_SAMPLES; i++)
            begin
                if (phase == 2 && i == PHASE_SAMPLES / 2)
                    drain();
                push_sample(pick_sample(),
                            ($urandom_range(0, 99) < 3) ||
                            (phase == PHASES - 1 && i == PHASE_SAMPLES - 1));
            end
        end
        calm = 1'b0;
        settle();

        $display("Sent %0d samples over %0d random phases plus directed cases.",
                 samples_sent, PHASES);
        $display("Checked %0d block results against the predicted levels and bars.",
                 blocks_checked);
        if (mismatches == 0 && blocks_waiting == 0)
            $display("audio_block_rms_peak_meter test passed");
        else
            $display("audio_block_rms_peak_meter test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ablm_pkg.sv
rtl/ablm_div.sv
rtl/ablm_sqrt.sv
rtl/ablm_datapath.sv
rtl/ablm_ctrl.sv
rtl/audio_block_rms_peak_meter.sv
tb/ablm_checker.sv
tb/tb_audio_block_rms_peak_meter.sv
